// ----- sv/afdc_pkg.sv -----
// Package with the shared types, constants and functions of the frame deframer.
`timescale 1ns / 1ps

package afdc_pkg;

    localparam int ByteW   = 8;
    localparam int LenW    = 16;
    localparam int ClassW  = 3;

    typedef logic [ByteW-1:0]  t_byte;
    typedef logic [LenW-1:0]   t_len;
    typedef logic [ClassW-1:0] t_class;

    localparam t_byte START_DELIM = 8'h7E;
    localparam t_byte CHK_INIT    = 8'hFF;

    localparam t_class CLS_OK        = 3'd0;
    localparam t_class CLS_ERROR     = 3'd1;
    localparam t_class CLS_BAD_CMD   = 3'd2;
    localparam t_class CLS_BAD_PARAM = 3'd3;
    localparam t_class CLS_TX_FAIL   = 3'd4;
    localparam t_class CLS_UNKNOWN   = 3'd5;

    function automatic t_class classify_status(input t_byte s);
        t_class c;
        case (s)
            8'd0:    c = CLS_OK;
            8'd1:    c = CLS_ERROR;
            8'd2:    c = CLS_BAD_CMD;
            8'd3:    c = CLS_BAD_PARAM;
            8'd4:    c = CLS_TX_FAIL;
            default: c = CLS_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/afdc_if.sv -----
// Channel interfaces for received bytes and for frame summaries.
`timescale 1ns / 1ps

interface afdc_in_if
    import afdc_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface afdc_out_if
    import afdc_pkg::*;
;
    logic   valid;
    logic   ready;
    t_len   frame_length;
    logic   checksum_ok;
    t_byte  computed_checksum;
    t_byte  received_checksum;
    t_byte  status_byte;
    t_class status_class;

    modport source (
        output valid, output frame_length, output checksum_ok,
        output computed_checksum, output received_checksum,
        output status_byte, output status_class, input ready
    );
    modport sink (
        input valid, input frame_length, input checksum_ok,
        input computed_checksum, input received_checksum,
        input status_byte, input status_class, output ready
    );
endinterface

// ----- sv/api_frame_deframer_checksum.sv -----
// Top level of the delimited frame deframer with additive checksum check.
//
//  Channel   Direction  Payload
//  i_rx      in         rx_byte (8 bits)
//  o_res     out        frame length, both checksums, match flag, status byte and class
//
// One byte is taken every cycle unless the pipeline stalls; a frame summary follows its checksum byte.
// The byte sits in an input register, and the frame state and result register update from it.
// A stalled result holds the pipeline only while the input register is full.
// Synchronous active-low reset returns the parser to hunting for the start delimiter.
`timescale 1ns / 1ps

module api_frame_deframer_checksum
    import afdc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    afdc_in_if.sink    i_rx,
    afdc_out_if.source o_res
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    logic       r_in_valid;
    t_byte      r_in_byte;

    logic [2:0] r_phase, n_phase;
    t_len       r_length, n_length;
    t_len       r_remaining, n_remaining;
    t_byte      r_sum, n_sum;
    t_byte      r_prev, n_prev;

    logic       r_out_valid;
    t_len       r_out_length;
    logic       r_out_ok;
    t_byte      r_out_calc;
    t_byte      r_out_rcv;
    t_byte      r_out_status;
    t_class     r_out_class;

    logic       w_adv;
    logic       w_emit;
    t_byte      w_calc;
    t_len       w_rem_dec;

    assign w_adv      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || w_adv;
    assign w_calc     = CHK_INIT - r_sum;
    assign w_rem_dec  = r_remaining - t_len'(1);
    assign w_emit     = (r_phase == PH_CHECK);

    always_comb begin
        n_phase     = r_phase;
        n_length    = r_length;
        n_remaining = r_remaining;
        n_sum       = r_sum;
        n_prev      = r_prev;
        unique case (r_phase)
            PH_LEN_HI: begin
                n_length = {r_in_byte, 8'h00};
                n_prev   = r_in_byte;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_length    = {r_length[LenW-1:ByteW], r_in_byte};
                n_remaining = {r_length[LenW-1:ByteW], r_in_byte};
                n_sum       = '0;
                n_prev      = r_in_byte;
                n_phase     = ({r_length[LenW-1:ByteW], r_in_byte} == '0) ?
                              PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_sum       = r_sum + r_in_byte;
                n_prev      = r_in_byte;
                n_remaining = w_rem_dec;
                if (w_rem_dec == '0) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase     = PH_HUNT;
                n_remaining = '0;
                n_sum       = '0;
                n_prev      = r_in_byte;
            end
            default: begin
                if (r_in_byte == START_DELIM) begin
                    n_phase     = PH_LEN_HI;
                    n_length    = '0;
                    n_remaining = '0;
                    n_sum       = '0;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_length    <= '0;
            r_remaining <= '0;
            r_sum       <= '0;
            r_prev      <= '0;
        end else if (w_adv) begin
            r_phase     <= n_phase;
            r_length    <= n_length;
            r_remaining <= n_remaining;
            r_sum       <= n_sum;
            r_prev      <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv && w_emit) begin
            r_out_length <= r_length;
            r_out_ok     <= (w_calc == r_in_byte);
            r_out_calc   <= w_calc;
            r_out_rcv    <= r_in_byte;
            r_out_status <= r_prev;
            r_out_class  <= classify_status(r_prev);
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.frame_length      = r_out_length;
    assign o_res.checksum_ok       = r_out_ok;
    assign o_res.computed_checksum = r_out_calc;
    assign o_res.received_checksum = r_out_rcv;
    assign o_res.status_byte       = r_out_status;
    assign o_res.status_class      = r_out_class;

endmodule
